/* sv/dqsr_pkg.sv */
// ----------------------------------------------------------------------------
// dqsr_pkg: shared types, constants and helpers for the bounded deque
// Sizes of the slot ring, field widths, operation and status codes and
// the ring index arithmetic used by the controller.
// ----------------------------------------------------------------------------
package dqsr_pkg;

  // ring geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // field widths
  localparam int DATA_W = 64;
  localparam int OP_W   = 3;
  localparam int POS_W  = 4;
  localparam int ST_W   = 3;
  localparam int OCC_W  = 5;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // stream payload widths, padded to whole bytes
  localparam int IN_RAW_W    = 2 * DATA_W + POS_W;
  localparam int IN_DATA_W   = ((IN_RAW_W + 7) / 8) * 8;
  localparam int IN_PAD_W    = IN_DATA_W - IN_RAW_W;
  localparam int OUT_RAW_W   = DATA_W + OCC_W;
  localparam int OUT_DATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_RAW_W;
  localparam int USER_W      = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_ADD_FRONT    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_BACK     = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_BACK  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_POS     = 3'd4;
  localparam logic [OP_W-1:0] OP_REPLACE      = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  // slot memory access request
  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr;
  } ram_req_t;

  // slot at a given offset from the front, wrapping around the ring
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  // slot just ahead of the front, wrapping around the ring
  function automatic idx_t ring_dec(idx_t base);
    idx_t res;
    if (base == '0) begin
      res = idx_t'(CAPACITY - 1);
    end else begin
      res = base - 1'b1;
    end
    return res;
  endfunction

endpackage

/* sv/dqsr_ram.sv */
// ----------------------------------------------------------------------------
// dqsr_ram: slot storage of the deque
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dqsr_ram (
  input  logic               clk,
  input  dqsr_pkg::ram_req_t req,
  output dqsr_pkg::word_t    rdata
);
  import dqsr_pkg::*;

  word_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

/* sv/bounded_deque_with_search_replace_top.sv */
// ----------------------------------------------------------------------------
// bounded_deque_with_search_replace_top: bounded deque with search and replace
// Ring of CAPACITY 64-bit slots in a synchronous memory, front pointer and
// count in registers; six request kinds, one result per request.
//
//   channel   | dir | tdata                                    | tuser
//   s_axis    | in  | value, new_value, position (+pad)        | operation
//   m_axis    | out | read_value, occupancy (+pad)             | status
//
// Steps: add, remove and unused codes pass through accept, execute and
// finish, the result register loading in finish; a read adds a state that
// takes the slot memory read; a replace adds one search step per entry
// scanned, up to CAPACITY, since the single read port of the slot memory
// delivers one entry per cycle.
// Reset clears front pointer, count, state and output valid; slot contents
// are left as they are and are read only after being written.
// A result waiting in the output register does not block the next request;
// the controller holds only if a second result is ready before it is taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_replace_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // value[63:0], new_value[127:64], position[131:128], zero pad
  input  logic [dqsr_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // operation[2:0]
  input  logic [dqsr_pkg::USER_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_value[63:0], occupancy[68:64], zero pad
  output logic [dqsr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[2:0]
  output logic [dqsr_pkg::USER_W-1:0]         m_axis_tuser
);
  import dqsr_pkg::*;

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]      state, state_next;
  idx_t            front, front_next;
  cnt_t            count, count_next;
  cnt_t            scan, scan_next;
  word_t           res_rd, res_rd_next;
  logic [ST_W-1:0] res_st, res_st_next;

  logic [OP_W-1:0]  op_r;
  word_t            val_r;
  word_t            nval_r;
  logic [POS_W-1:0] pos_r;

  ram_req_t req;
  word_t    rdata;

  logic       full;
  logic       empty;
  logic       pos_bad;
  logic       out_load;
  cnt_t       scan_inc;

  dqsr_ram u_ram (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign full          = (count == cnt_t'(CAPACITY));
  assign empty         = (count == '0);
  assign pos_bad       = (CMP_W'(pos_r) >= CMP_W'(count));
  assign scan_inc      = cnt_t'(scan + 1'b1);
  assign out_load      = (state == S_FINISH) && (!m_axis_tvalid || m_axis_tready);

  // request capture
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_r   <= s_axis_tuser[OP_W-1:0];
      val_r  <= s_axis_tdata[DATA_W-1:0];
      nval_r <= s_axis_tdata[2*DATA_W-1:DATA_W];
      pos_r  <= s_axis_tdata[2*DATA_W+POS_W-1:2*DATA_W];
    end
  end

  // controller: pointer update, memory requests, entry scan
  always_comb begin
    state_next  = state;
    front_next  = front;
    count_next  = count;
    scan_next   = scan;
    res_rd_next = res_rd;
    res_st_next = res_st;
    req         = '0;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_rd_next = '0;
        res_st_next = ST_OK;
        state_next  = S_FINISH;
        case (op_r)
          OP_ADD_FRONT: begin
            if (full) begin
              res_st_next = ST_FULL;
            end else begin
              front_next = ring_dec(front);
              count_next = cnt_t'(count + 1'b1);
              req.we     = 1'b1;
              req.waddr  = ring_dec(front);
              req.wdata  = val_r;
            end
          end
          OP_REMOVE_FRONT: begin
            if (empty) begin
              res_st_next = ST_EMPTY;
            end else begin
              front_next = ring_add(front, cnt_t'(1));
              count_next = cnt_t'(count - 1'b1);
            end
          end
          OP_ADD_BACK: begin
            if (full) begin
              res_st_next = ST_FULL;
            end else begin
              count_next = cnt_t'(count + 1'b1);
              req.we     = 1'b1;
              req.waddr  = ring_add(front, count);
              req.wdata  = val_r;
            end
          end
          OP_REMOVE_BACK: begin
            if (empty) begin
              res_st_next = ST_EMPTY;
            end else begin
              count_next = cnt_t'(count - 1'b1);
            end
          end
          OP_READ_POS: begin
            if (pos_bad) begin
              res_st_next = ST_RANGE;
            end else begin
              req.re     = 1'b1;
              req.raddr  = ring_add(front, cnt_t'(pos_r));
              state_next = S_READ;
            end
          end
          OP_REPLACE: begin
            if (empty) begin
              res_st_next = ST_NOTFOUND;
            end else begin
              req.re     = 1'b1;
              req.raddr  = front;
              scan_next  = '0;
              state_next = S_SEARCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        res_rd_next = rdata;
        state_next  = S_FINISH;
      end
      S_SEARCH: begin
        // rdata holds the entry at offset scan
        if (rdata == val_r) begin
          req.we     = 1'b1;
          req.waddr  = ring_add(front, scan);
          req.wdata  = nval_r;
          state_next = S_FINISH;
        end else if (scan_inc == count) begin
          res_st_next = ST_NOTFOUND;
          state_next  = S_FINISH;
        end else begin
          scan_next = scan_inc;
          req.re    = 1'b1;
          req.raddr = ring_add(front, scan_inc);
        end
      end
      S_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    scan   <= scan_next;
    res_rd <= res_rd_next;
    res_st <= res_st_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {{OUT_PAD_W{1'b0}}, OCC_W'(count), res_rd};
      m_axis_tuser <= USER_W'(res_st);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_ram_one_access: assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re))
    else $error("slot memory read and written in the same cycle");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> (state == S_EXEC))
    else $error("accepted transfer not executed");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable(count) && $stable(front))
    else $error("pointer state changed outside execute");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the bounded deque with search and replace
// A directed table covers empty and full refusals, reads past the count,
// failed and successful replaces, the unused opcodes and the value
// extremes. It is followed by random traffic that sweeps the deque between
// empty and full. Every accepted request goes through a behavioral model of
// the ring. Each result transfer is checked field by field against the
// oldest prediction. Both stream sides throttle at random outside the last phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dqsr_pkg::*;

  // opcodes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int  RANDOM_PER_PHASE = 115;
  localparam int  CYCLE_LIMIT      = 200000;
  localparam word_t WORD_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam word_t WORD_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    word_t            read_value;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  // one line of the directed table
  typedef struct packed {
    logic [OP_W-1:0]  op;
    word_t            value;
    word_t            new_value;
    logic [POS_W-1:0] position;
    logic [7:0]       reps;
    logic             typed;
    deque_result_t    result;
  } deque_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [USER_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [USER_W-1:0]     m_axis_tuser;

  // model state of the ring
  word_t         ring_slots [CAPACITY];
  int            ring_front = 0;
  int            ring_count = 0;

  deque_result_t pending_results[$];
  deque_row_t    deque_script[$];
  deque_result_t seen_result;
  deque_result_t due_result;
  int            mismatches  = 0;
  int            cycle_count = 0;
  int            tx_idle_pct = 11;
  int            rx_idle_pct = 69;

  bounded_deque_with_search_replace_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // apply one request to the ring model and return its result
  function automatic deque_result_t apply_request(logic [OP_W-1:0] op, word_t value,
                                                  word_t new_value, logic [POS_W-1:0] position);
    deque_result_t res;
    int            slot;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_ADD_FRONT: begin
        if (ring_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          ring_front = (ring_front + CAPACITY - 1) % CAPACITY;
          ring_slots[ring_front] = value;
          ring_count++;
        end
      end
      OP_REMOVE_FRONT: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ring_front = (ring_front + 1) % CAPACITY;
          ring_count--;
        end
      end
      OP_ADD_BACK: begin
        if (ring_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          ring_slots[(ring_front + ring_count) % CAPACITY] = value;
          ring_count++;
        end
      end
      OP_REMOVE_BACK: begin
        if (ring_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          ring_count--;
        end
      end
      OP_READ_POS: begin
        if (int'(position) >= ring_count) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = ring_slots[(ring_front + int'(position)) % CAPACITY];
        end
      end
      OP_REPLACE: begin
        // first match from the front wins
        res.status = ST_NOTFOUND;
        for (int i = 0; i < ring_count; i++) begin
          slot = (ring_front + i) % CAPACITY;
          if (res.status == ST_NOTFOUND && ring_slots[slot] == value) begin
            ring_slots[slot] = new_value;
            res.status = ST_OK;
          end
        end
      end
      default: begin
      end
    endcase
    res.occupancy = OCC_W'(ring_count);
    return res;
  endfunction

  // random 64-bit value, biased toward extremes and small repeats
  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(9))
      0:       w = '0;
      1:       w = WORD_MAX;
      2:       w = WORD_MIN;
      3:       w = '1;
      4, 5:    w = word_t'($urandom_range(3));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic script_row(logic [OP_W-1:0] op, word_t value, word_t new_value,
                            logic [POS_W-1:0] position, int reps, bit typed,
                            word_t rd, logic [ST_W-1:0] st, logic [OCC_W-1:0] occ);
    deque_row_t row;
    row.op        = op;
    row.value     = value;
    row.new_value = new_value;
    row.position  = position;
    row.reps      = 8'(reps);
    row.typed     = typed;
    row.result    = '{read_value: rd, status: st, occupancy: occ};
    deque_script.push_back(row);
  endtask

  // offer one request, wait for its transfer, then record what it should return
  task automatic submit_request(logic [OP_W-1:0] op, word_t value, word_t new_value,
                                logic [POS_W-1:0] position, bit typed,
                                deque_result_t typed_result);
    int            gap;
    deque_result_t predicted;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{IN_PAD_W{1'b0}}, position, new_value, value};
    s_axis_tuser  <= USER_W'(op);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = apply_request(op, value, new_value, position);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // result checking
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_result.read_value = m_axis_tdata[DATA_W-1:0];
      seen_result.occupancy  = m_axis_tdata[DATA_W+OCC_W-1:DATA_W];
      seen_result.status     = m_axis_tuser[ST_W-1:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: read_value %h status %0d occupancy %0d",
               seen_result.read_value, seen_result.status, seen_result.occupancy);
        mismatches++;
      end else begin
        due_result = pending_results.pop_front();
        if (seen_result.read_value !== due_result.read_value) begin
          $error("read_value mismatch: expected %h, got %h",
                 due_result.read_value, seen_result.read_value);
          mismatches++;
        end
        if (seen_result.status !== due_result.status) begin
          $error("status mismatch: expected %0d, got %0d",
                 due_result.status, seen_result.status);
          mismatches++;
        end
        if (seen_result.occupancy !== due_result.occupancy) begin
          $error("occupancy mismatch: expected %0d, got %0d",
                 due_result.occupancy, seen_result.occupancy);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [OP_W-1:0]  op;
    word_t            value;
    word_t            new_value;
    logic [POS_W-1:0] position;
    int               made;
    int               pick;
    bit               filling;

    // op, value, new_value, position, reps, typed, read_value, status, occupancy
    script_row(OP_REMOVE_FRONT, '0, '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0);
    script_row(OP_REMOVE_BACK, '0, '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0);
    script_row(OP_READ_POS, '0, '0, 4'd0, 1, 1, '0, ST_RANGE, 5'd0);
    script_row(OP_REPLACE, '0, '1, 4'd0, 1, 1, '0, ST_NOTFOUND, 5'd0);
    script_row(OP_UNUSED_LO, '1, '1, 4'd15, 1, 1, '0, ST_OK, 5'd0);
    script_row(OP_UNUSED_HI, '1, '1, 4'd15, 1, 1, '0, ST_OK, 5'd0);
    script_row(OP_ADD_BACK, WORD_MAX, '0, 4'd0, 1, 1, '0, ST_OK, 5'd1);
    script_row(OP_ADD_FRONT, WORD_MIN, '0, 4'd0, 1, 1, '0, ST_OK, 5'd2);
    script_row(OP_READ_POS, '0, '0, 4'd0, 1, 1, WORD_MIN, ST_OK, 5'd2);
    script_row(OP_READ_POS, '0, '0, 4'd1, 1, 1, WORD_MAX, ST_OK, 5'd2);
    script_row(OP_READ_POS, '0, '0, 4'd15, 1, 1, '0, ST_RANGE, 5'd2);
    script_row(OP_REPLACE, WORD_MAX, '1, 4'd0, 1, 1, '0, ST_OK, 5'd2);
    script_row(OP_READ_POS, '0, '0, 4'd1, 1, 1, '1, ST_OK, 5'd2);
    script_row(OP_REPLACE, 64'd5, '0, 4'd0, 1, 1, '0, ST_NOTFOUND, 5'd2);
    // fill to capacity with ascending values
    script_row(OP_ADD_BACK, 64'h5555_5555_5555_5555, '0, 4'd0, 14, 0, '0, ST_OK, '0);
    script_row(OP_ADD_FRONT, 64'd9, '0, 4'd0, 1, 1, '0, ST_FULL, 5'd16);
    script_row(OP_ADD_BACK, 64'd9, '0, 4'd0, 1, 1, '0, ST_FULL, 5'd16);
    script_row(OP_READ_POS, '0, '0, 4'd15, 1, 0, '0, ST_OK, '0);
    // match sits in the last slot, so the search runs the whole ring
    script_row(OP_REPLACE, 64'h5555_5555_5555_5562, 64'haaaa_aaaa_aaaa_aaaa, 4'd0, 1, 0,
               '0, ST_OK, '0);
    script_row(OP_READ_POS, '0, '0, 4'd15, 1, 0, '0, ST_OK, '0);
    script_row(OP_REMOVE_FRONT, '0, '0, 4'd0, 16, 0, '0, ST_OK, '0);
    script_row(OP_REMOVE_FRONT, '0, '0, 4'd0, 1, 1, '0, ST_EMPTY, 5'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (deque_script[r]) begin
      for (int k = 0; k < int'(deque_script[r].reps); k++) begin
        submit_request(deque_script[r].op, deque_script[r].value + word_t'(k),
                       deque_script[r].new_value, deque_script[r].position,
                       deque_script[r].typed, deque_script[r].result);
      end
    end

    // random traffic, swinging between filling and draining the ring
    filling = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        1: begin
          tx_idle_pct = 69;
          rx_idle_pct = 11;
        end
        2: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        default: begin
          tx_idle_pct = 11;
          rx_idle_pct = 69;
        end
      endcase
      made = 0;
      while (made < RANDOM_PER_PHASE) begin
        if (ring_count == CAPACITY && $urandom_range(9) < 3) filling = 1'b0;
        if (ring_count == 0 && $urandom_range(9) < 3) filling = 1'b1;
        value     = random_word();
        new_value = random_word();
        position  = POS_W'($urandom_range(15));
        pick      = $urandom_range(99);
        if (pick < 2) begin
          op = (pick == 0) ? OP_UNUSED_LO : OP_UNUSED_HI;
        end else if (pick < (filling ? 57 : 22)) begin
          op = $urandom_range(1) ? OP_ADD_FRONT : OP_ADD_BACK;
        end else if (pick < 77) begin
          op = $urandom_range(1) ? OP_REMOVE_FRONT : OP_REMOVE_BACK;
        end else if (pick < 90) begin
          op = OP_READ_POS;
          if (ring_count > 0 && $urandom_range(3) != 0) begin
            position = POS_W'($urandom_range(ring_count - 1));
          end
        end else begin
          op = OP_REPLACE;
          // mostly search for a value that is stored
          if (ring_count > 0 && $urandom_range(9) < 7) begin
            value = ring_slots[(ring_front + $urandom_range(ring_count - 1)) % CAPACITY];
          end
        end
        submit_request(op, value, new_value, position, 1'b0, '0);
        if (op != OP_UNUSED_LO && op != OP_UNUSED_HI) made++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
